>>> hw/rtl/ast_pkg.sv
`timescale 1ns / 1ps

package ast_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed field widths of the beats
  localparam int OP_W     = 2;
  localparam int IO_KEY_W = 32;
  localparam int SIZE_W   = 7;
  localparam int STAT_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CONTAINS = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
  localparam logic [OP_W-1:0] OP_POP      = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

  typedef struct packed {
    logic        [OP_W-1:0]     operation;
    logic signed [IO_KEY_W-1:0] key;
  } ast_in_t;

  typedef struct packed {
    logic                       found;
    logic signed [IO_KEY_W-1:0] popped_value;
    logic        [SIZE_W-1:0]   size_after;
    logic        [STAT_W-1:0]   status;
  } ast_out_t;

endpackage

>>> hw/rtl/ast_ram.sv
`timescale 1ns / 1ps

module ast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/array_set_table_top.sv
`timescale 1ns / 1ps

// Array set table. Holds up to CAPACITY distinct keys in insertion order,
// plus a count. Each beat on in_item is one operation: insert, contains,
// remove a key (the gap is closed, order kept) or pop the first entry.
// A beat is taken on a rising edge with start high and busy low; busy then
// stays high until the result is produced. Every operation gives exactly
// one result beat: out_strobe is high for a single cycle with out_item
// valid, and the receiver cannot stall it, so it must take the beat in that
// cycle. busy is already low in the cycle the result appears, so the next
// operation may start right then.
// Timing is set by the single-port-read entry RAM, which is walked one
// entry per cycle; the result strobe comes in the cycle after the last
// busy cycle. Insert and contains scan until the key is found or every
// held key has been read. Remove scans to the key, then moves each later
// entry down one slot (none when the key is the last entry). Pop takes
// the first entry, then moves the rest down one slot. Any op on an empty
// set reads no entry; a pop there never raises busy and its strobe comes
// in the cycle after the beat. Reset clears the state, the count and the
// strobe but not the entries; they are never read above the count, so no
// clearing pass.

module array_set_table_top #(
  parameter int CAPACITY  = ast_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = ast_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ast_pkg::ast_in_t  in_item,
  output logic              out_strobe,
  output ast_pkg::ast_out_t out_item
);

  import ast_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);      // entry address
  localparam int CNT_W = $clog2(CAPACITY + 1);  // count, 0..CAPACITY

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;  // walk entries, compare to key
  localparam logic [1:0] ST_SHIFT = 2'd2;  // move entries down one slot

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;        // next RAM read address
  logic                 pend_r, pend_nxt;      // read data valid this cycle
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;      // address of that data
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [IO_KEY_W-1:0]  pop_r, pop_nxt;

  logic                 out_strobe_r, done;
  ast_out_t             out_item_r, res;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [KEY_WIDTH-1:0] rd_data;

  logic                 issue_ok;
  logic                 key_match;

  // Width adapters: key from beat to KEY_WIDTH, entry to output, count to size
  logic [KEY_WIDTH+IO_KEY_W-1:0] key_ext;
  logic [KEY_WIDTH+IO_KEY_W-1:0] rd_ext;
  logic [CNT_W+SIZE_W-1:0]       size_ext;

  assign key_ext  = {{KEY_WIDTH{1'b0}}, in_item.key};
  assign rd_ext   = {{IO_KEY_W{1'b0}}, rd_data};
  assign size_ext = {{SIZE_W{1'b0}}, count_nxt};

  ast_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_entries (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign issue_ok  = (idx_r < count_r);
  // A pop takes whatever comes back first, which is entry zero
  assign key_match = pend_r && ((op_r == OP_POP) || (rd_data == key_r));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = pidx_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    pop_nxt   = pop_r;
    we        = 1'b0;
    waddr     = pidx_r - 1'b1;
    wdata     = rd_data;
    done      = 1'b0;
    res.found        = 1'b0;
    res.popped_value = '0;
    res.status       = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = in_item.operation;
          key_nxt = key_ext[KEY_WIDTH-1:0];
          idx_nxt = '0;
          if ((in_item.operation == OP_POP) && (count_r == '0)) begin
            done       = 1'b1;
            res.status = STAT_EMPTY;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (issue_ok) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
        end
        if (key_match) begin
          if ((op_r == OP_INSERT) || (op_r == OP_CONTAINS)) begin
            done      = 1'b1;
            res.found = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            // close the gap starting from the entry after the match
            pop_nxt   = (op_r == OP_POP) ? rd_ext[IO_KEY_W-1:0] : '0;
            idx_nxt   = CNT_W'(pidx_r) + 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = ST_SHIFT;
          end
        end else if (!pend_r && !issue_ok) begin
          // scanned everything, key absent
          done      = 1'b1;
          state_nxt = ST_IDLE;
          case (op_r)
            OP_INSERT: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                res.status = STAT_FULL;
              end else begin
                we        = 1'b1;
                waddr     = count_r[IDX_W-1:0];
                wdata     = key_r;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_REMOVE: res.status = STAT_ABSENT;
            default:   res.status = STAT_OK;
          endcase
        end
      end

      ST_SHIFT: begin
        if (issue_ok) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
        end
        if (pend_r) begin
          we = 1'b1;
        end else if (!issue_ok) begin
          count_nxt        = count_r - 1'b1;
          done             = 1'b1;
          res.found        = 1'b1;
          res.popped_value = pop_r;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.size_after = size_ext[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= done;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    pop_r  <= pop_nxt;
    if (done) begin
      out_item_r <= res;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
